// ===== design/sfp_pkg.sv =====
// Package for the SETTINGS frame parser: request payload types, control/status
// structs shared by the controller and the datapath, and protocol constants.
// No dependencies.
package sfp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_frame;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [61:0] table_capacity;
    logic [63:0] field_section_limit;
    logic [61:0] blocked_streams;
  } out_item_t;

  typedef struct packed {
    logic take;    // decode the accepted byte
    logic search;  // step the duplicate search
    logic commit;  // resolve the finished pair
    logic emit;    // load the result register
    logic dflt;    // result carries the defaults
    logic clear;   // return frame state to reset values
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic pair_ends;
    logic search_done;
  } sts_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  localparam logic [61:0] ID_CAP      = 62'h1;
  localparam logic [61:0] ID_RSV_LO   = 62'h2;
  localparam logic [61:0] ID_RSV_HI   = 62'h5;
  localparam logic [61:0] ID_LIMIT    = 62'h6;
  localparam logic [61:0] ID_BLOCKED  = 62'h7;

  localparam logic [63:0] LIMIT_DFLT  = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

// ===== design/sfp_ctrl.sv =====
// Controller for the SETTINGS frame parser: sequences byte intake, the
// duplicate search, pair resolution and result emission.
// Depends on sfp_pkg.
module sfp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_free,
  input  sfp_pkg::sts_t sts,
  output sfp_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_COMMIT = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   last_pend_r, last_pend_nxt;

  always_comb begin
    state_nxt     = state_r;
    last_pend_nxt = last_pend_r;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          if (sts.empty) begin
            cmd.clear = 1'b1;
            cmd.dflt  = 1'b1;
            cmd.emit  = 1'b1;
          end else begin
            cmd.take      = 1'b1;
            last_pend_nxt = sts.last;
            if (sts.pair_ends) begin
              state_nxt = S_SEARCH;
            end else if (sts.last) begin
              state_nxt = S_EMIT;
            end
          end
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.search_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = last_pend_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        cmd.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result emitted while result register stalled");
  a_search_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && sts.search_done) |=> cmd.commit)
    else $error("finished search not followed by commit");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE && out_free))
    else $error("request taken outside idle");
`endif

endmodule

// ===== design/sfp_dpath.sv =====
// Datapath for the SETTINGS frame parser: varint decoder, seen-identifier
// memory with sequential duplicate search, settings registers, result format.
// Depends on sfp_pkg.
module sfp_dpath #(
  parameter int MAX_IDS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfp_pkg::in_item_t  in_data,
  input  sfp_pkg::cmd_t      cmd,
  output sfp_pkg::sts_t      sts,
  output sfp_pkg::out_item_t result
);

  localparam int CNT_W = $clog2(MAX_IDS + 1);
  localparam int IDX_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

  logic              phase_r, phase_nxt;
  logic [2:0]        bl_r, bl_nxt;
  logic [61:0]       acc_r, acc_nxt;
  logic [61:0]       ident_r, ident_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              err_r, err_nxt;
  logic [61:0]       cap_r, cap_nxt;
  logic [63:0]       limit_r, limit_nxt;
  logic [61:0]       blocked_r, blocked_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic              dup_r, dup_nxt;

  logic [61:0]       seen_mem [MAX_IDS];
  logic [61:0]       rd_q;
  logic              mem_we;

  logic [61:0]       acc_dec;
  logic [2:0]        bl_dec;
  logic              reserved;
  logic              full;
  logic              pair_ok;

  // varint byte decode
  always_comb begin
    if (bl_r == 3'd0) begin
      acc_dec = {56'd0, in_data.data_byte[5:0]};
      bl_dec  = 3'((4'd1 << in_data.data_byte[7:6]) - 4'd1);
    end else begin
      acc_dec = {acc_r[53:0], in_data.data_byte};
      bl_dec  = bl_r - 3'd1;
    end
  end

  assign reserved = (ident_r >= sfp_pkg::ID_RSV_LO) && (ident_r <= sfp_pkg::ID_RSV_HI);
  assign full     = (cnt_r == CNT_W'(MAX_IDS));
  assign pair_ok  = !reserved && !dup_r && !full;
  assign mem_we   = cmd.commit && pair_ok;

  assign sts.empty       = in_data.empty_frame;
  assign sts.last        = in_data.last_byte;
  assign sts.pair_ends   = !err_r && (bl_dec == 3'd0) && phase_r;
  assign sts.search_done = (ptr_r == cnt_r) && !pend_r;

  always_comb begin
    phase_nxt   = phase_r;
    bl_nxt      = bl_r;
    acc_nxt     = acc_r;
    ident_nxt   = ident_r;
    cnt_nxt     = cnt_r;
    err_nxt     = err_r;
    cap_nxt     = cap_r;
    limit_nxt   = limit_r;
    blocked_nxt = blocked_r;
    ptr_nxt     = ptr_r;
    pend_nxt    = pend_r;
    dup_nxt     = dup_r;

    if (cmd.take) begin
      ptr_nxt  = '0;
      pend_nxt = 1'b0;
      dup_nxt  = 1'b0;
      if (!err_r) begin
        acc_nxt = acc_dec;
        bl_nxt  = bl_dec;
        if (bl_dec == 3'd0) begin
          if (!phase_r) begin
            ident_nxt = acc_dec;
            phase_nxt = 1'b1;
          end else begin
            phase_nxt = 1'b0;
          end
        end
      end
    end

    if (cmd.search) begin
      if (ptr_r < cnt_r) begin
        ptr_nxt  = ptr_r + CNT_W'(1);
        pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
      if (pend_r && (rd_q == ident_r)) begin
        dup_nxt = 1'b1;
      end
    end

    if (cmd.commit) begin
      if (!pair_ok) begin
        err_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (ident_r == sfp_pkg::ID_CAP) begin
          cap_nxt = acc_r;
        end else if (ident_r == sfp_pkg::ID_LIMIT) begin
          limit_nxt = {2'b00, acc_r};
        end else if (ident_r == sfp_pkg::ID_BLOCKED) begin
          blocked_nxt = acc_r;
        end
      end
    end

    if (cmd.clear) begin
      phase_nxt   = 1'b0;
      bl_nxt      = '0;
      acc_nxt     = '0;
      ident_nxt   = '0;
      cnt_nxt     = '0;
      err_nxt     = 1'b0;
      cap_nxt     = '0;
      limit_nxt   = sfp_pkg::LIMIT_DFLT;
      blocked_nxt = '0;
    end
  end

  always_comb begin
    if (cmd.dflt) begin
      result.status              = sfp_pkg::ST_OK;
      result.table_capacity      = '0;
      result.field_section_limit = sfp_pkg::LIMIT_DFLT;
      result.blocked_streams     = '0;
    end else begin
      if (err_r) begin
        result.status = sfp_pkg::ST_ERR;
      end else if ((bl_r != 3'd0) || phase_r) begin
        result.status = sfp_pkg::ST_TRUNC;
      end else begin
        result.status = sfp_pkg::ST_OK;
      end
      result.table_capacity      = cap_r;
      result.field_section_limit = limit_r;
      result.blocked_streams     = blocked_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seen_mem[cnt_r[IDX_W-1:0]] <= ident_r;
    end
    rd_q <= seen_mem[ptr_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 1'b0;
      bl_r      <= '0;
      acc_r     <= '0;
      ident_r   <= '0;
      cnt_r     <= '0;
      err_r     <= 1'b0;
      cap_r     <= '0;
      limit_r   <= sfp_pkg::LIMIT_DFLT;
      blocked_r <= '0;
      ptr_r     <= '0;
      pend_r    <= 1'b0;
      dup_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      bl_r      <= bl_nxt;
      acc_r     <= acc_nxt;
      ident_r   <= ident_nxt;
      cnt_r     <= cnt_nxt;
      err_r     <= err_nxt;
      cap_r     <= cap_nxt;
      limit_r   <= limit_nxt;
      blocked_r <= blocked_nxt;
      ptr_r     <= ptr_nxt;
      pend_r    <= pend_nxt;
      dup_r     <= dup_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_IDS))
    else $error("seen count beyond table depth");
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.search |-> (ptr_r <= cnt_r))
    else $error("search pointer past seen count");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r && !cmd.clear) |=> err_r)
    else $error("latched error dropped mid-frame");
`endif

endmodule

// ===== design/settings_frame_parser_top.sv =====
// SETTINGS frame parser, top level: controller, datapath and result register.
// Depends on sfp_pkg, sfp_ctrl, sfp_dpath.
//
// Usage:
//   in_*  : one payload byte per request (data_byte, last_byte, empty_frame).
//   out_* : one result per frame (status and the three settings), given for
//           a request with last_byte or empty_frame set.
//   A byte that neither finishes an identifier/value pair nor ends the frame
//   leaves the controller idle. A byte that finishes a pair with no error
//   latched holds in_ready low for the duplicate search over the identifiers
//   seen so far, one memory read per cycle over N stored identifiers
//   (N <= MAX_IDS), then for the commit of the pair. A last byte also
//   passes through the emit state. The result register loads a result in
//   the emit state after its last byte or the commit of the pair it ends;
//   an empty frame gives its result the cycle after acceptance.
//   Results wait in a single output register; in_ready stays low while
//   that register is full and out_ready is low, so no request is lost.
//   Reset (rst_n low, synchronous) empties the result register and returns
//   all frame state to defaults; the seen-identifier memory needs no clear.
module settings_frame_parser_top #(
  parameter int MAX_IDS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sfp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sfp_pkg::out_item_t out_data
);

  sfp_pkg::cmd_t      cmd;
  sfp_pkg::sts_t      sts;
  sfp_pkg::out_item_t result;
  logic               out_free;
  logic               out_valid_r, out_valid_nxt;
  sfp_pkg::out_item_t out_data_r;

  assign out_free = !out_valid_r || out_ready;

  sfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfp_dpath #(
    .MAX_IDS (MAX_IDS)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted result not presented");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.emit)
    else $error("held result overwritten");
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("request taken while result stalled");
`endif

endmodule
